// ===== rtl/mcpi_pkg.sv =====
// Shared types, codes and constants for the multichannel PI controller.
`timescale 1ns / 1ps
package mcpi_pkg;

	// field widths
	localparam int ERR_W   = 24;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 31;
	localparam int ACC_W   = 32;
	localparam int DRV_W   = 32;
	localparam int CH_W    = 8;
	localparam int ACT_W   = 9;
	localparam int PE_W    = GAIN_W + 1 + ERR_W;
	localparam int PI_W    = GAIN_W + 1 + ACC_W;

	// channel space addressable by the channel field
	localparam int CH_SPACE     = 256;
	localparam int CHANNELS_DEF = 256;

	// register reset values
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd4096;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd410;
	localparam logic [LIM_W-1:0]  INTEG_LIM_RST  = 31'd409600;
	localparam logic [ACT_W-1:0]  ACTIVE_RST     = 9'd256;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [1:0] REG_INTEG_LIM  = 2'd2;
	localparam logic [1:0] REG_ACTIVE     = 2'd3;

	// op codes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_CLEAR = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	// per-stage tag that travels with each word
	typedef struct packed {
		logic            vld;
		status_t         kind;
		logic [CH_W-1:0] ch;
	} tag_t;

endpackage

// ===== rtl/mcpi_mac.sv =====
// Gain multiply, round off 12 fraction bits and saturate to 32 bits.
`timescale 1ns / 1ps
module mcpi_mac import mcpi_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [GAIN_W-1:0]        prop_gain,
	input  logic [GAIN_W-1:0]        integ_gain,
	input  logic signed [ERR_W-1:0]  err,
	input  logic signed [ACC_W-1:0]  acc,
	output logic signed [DRV_W-1:0]  drive_c,
	output logic                     sat_c
);

	localparam int SUM_W = PI_W + 1;

	logic signed [GAIN_W:0]   kp;
	logic signed [GAIN_W:0]   ki;
	logic signed [PE_W-1:0]   pe_c;
	logic signed [PI_W-1:0]   pi_c;
	logic signed [PE_W-1:0]   pe_s3;
	logic signed [PI_W-1:0]   pi_s3;
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  shifted;
	logic                     hi_pos;
	logic                     hi_neg;

	// gains are unsigned: zero-extend into the signed product
	assign kp   = {1'b0, prop_gain};
	assign ki   = {1'b0, integ_gain};
	assign pe_c = kp * err;
	assign pi_c = ki * acc;

	// product registers
	always_ff @(posedge clk) begin
		if (en) begin
			pe_s3 <= pe_c;
			pi_s3 <= pi_c;
		end
	end

	// round half up, then clip to the 32-bit range
	always_comb begin
		total   = SUM_W'(pe_s3) + SUM_W'(pi_s3) + SUM_W'(2048);
		shifted = total >>> 12;
		hi_pos  = ~shifted[SUM_W-1] & (|shifted[SUM_W-2:DRV_W-1]);
		hi_neg  = shifted[SUM_W-1] & ~(&shifted[SUM_W-2:DRV_W-1]);
		sat_c   = hi_pos | hi_neg;
		if (hi_pos) begin
			drive_c = {1'b0, {(DRV_W-1){1'b1}}};
		end else if (hi_neg) begin
			drive_c = {1'b1, {(DRV_W-1){1'b0}}};
		end else begin
			drive_c = shifted[DRV_W-1:0];
		end
	end

endmodule

// ===== rtl/multichannel_pi_antiwindup_unit.sv =====
// Multichannel PI controller with integrator clamp: top level.
// Pipeline from input accept to out_valid: read, clamp/write, multiply, round.
// Throughput: one word per cycle while the output is not stalled; integrator RMW hazards are covered by forwarding.
// A clear needs no sweep: per-entry valid flags are dropped at once.
// Reset: registers return to their defaults, all integrators read as zero,
// pipeline and output are empty. Integrator memory contents are not reset.
`timescale 1ns / 1ps
module multichannel_pi_antiwindup_unit import mcpi_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [ERR_W-1:0]  error_sample,
	// output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DRV_W-1:0]  drive,
	output logic [CH_W-1:0]          out_channel,
	output logic [1:0]               status,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int DEPTH = (CHANNELS < CH_SPACE) ? CHANNELS : CH_SPACE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOTS = 1 << AW;

	// configuration registers
	logic [GAIN_W-1:0] prop_gain_q;
	logic [GAIN_W-1:0] integ_gain_q;
	logic [LIM_W-1:0]  integ_limit_q;
	logic [ACT_W-1:0]  active_q;
	logic              cfg_wr;

	// stage 1: accepted word plus memory read
	logic                    v_s1;
	logic                    op_s1;
	logic [CH_W-1:0]         ch_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic                    inr_s1;
	logic signed [ACC_W-1:0] rd_s1;
	logic                    vb_s1;

	// stage 2 / 3 / output
	tag_t                    tag_s2;
	tag_t                    tag_s3;
	logic signed [ERR_W-1:0] err_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic                    out_valid_q;
	logic signed [DRV_W-1:0] drive_q;
	logic [CH_W-1:0]         out_channel_q;
	status_t                 status_q;

	// integrator store and its valid flags
	logic signed [ACC_W-1:0] integ_mem [SLOTS];
	logic [SLOTS-1:0]        ent_vld_q;

	// handshake and stage enables
	logic en1, en2, en3, adv_out;
	logic accept;
	logic in_range;

	// stage 1 datapath
	logic signed [ACC_W-1:0] integ_c;
	logic signed [ACC_W:0]   sum_c;
	logic signed [ACC_W:0]   lim_c;
	logic signed [ACC_W-1:0] acc_c;
	logic                    wr_en;
	logic                    clr_en;
	status_t                 kind_c;

	// mac results
	logic signed [DRV_W-1:0] drive_c;
	logic                    sat_c;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			integ_limit_q <= INTEG_LIM_RST;
			active_q      <= ACTIVE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PROP_GAIN:  prop_gain_q   <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q  <= pwdata[GAIN_W-1:0];
				REG_INTEG_LIM:  integ_limit_q <= pwdata[LIM_W-1:0];
				REG_ACTIVE:     active_q      <= pwdata[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PROP_GAIN:  prdata = 32'(prop_gain_q);
			REG_INTEG_GAIN: prdata = 32'(integ_gain_q);
			REG_INTEG_LIM:  prdata = 32'(integ_limit_q);
			REG_ACTIVE:     prdata = 32'(active_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// each stage moves when the next one is empty or moving
	assign adv_out  = ~out_valid_q | out_ready;
	assign en3      = ~tag_s3.vld | adv_out;
	assign en2      = ~tag_s2.vld | en3;
	assign en1      = ~v_s1 | en2;
	assign in_ready = en1;
	assign accept   = in_valid & en1;

	assign in_range = ({1'b0, channel} < active_q) && (32'(channel) < CHANNELS);

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			ch_s1  <= channel;
			err_s1 <= error_sample;
			inr_s1 <= in_range;
			vb_s1  <= ent_vld_q[channel[AW-1:0]];
		end
	end

	// integrator memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			integ_mem[ch_s1[AW-1:0]] <= acc_c;
		end
		if (accept) begin
			rd_s1 <= integ_mem[channel[AW-1:0]];
		end
	end

	// forward from the word one stage ahead, whose write may come after this word's read; a clear there forces zero
	always_comb begin
		if (tag_s2.vld && tag_s2.kind == ST_CLEAR) begin
			integ_c = '0;
		end else if (tag_s2.vld && tag_s2.kind == ST_OK && tag_s2.ch == ch_s1) begin
			integ_c = acc_s2;
		end else if (vb_s1) begin
			integ_c = rd_s1;
		end else begin
			integ_c = '0;
		end
	end

	// accumulate and clamp to +/- limit
	always_comb begin
		sum_c = {integ_c[ACC_W-1], integ_c} + (ACC_W+1)'(err_s1);
		lim_c = {2'b00, integ_limit_q};
		if (sum_c > lim_c) begin
			acc_c = lim_c[ACC_W-1:0];
		end else if (sum_c < -lim_c) begin
			acc_c = ACC_W'(-lim_c);
		end else begin
			acc_c = sum_c[ACC_W-1:0];
		end
	end

	always_comb begin
		if (op_s1 == OP_CLEAR) begin
			kind_c = ST_CLEAR;
		end else if (!inr_s1) begin
			kind_c = ST_RANGE;
		end else begin
			kind_c = ST_OK;
		end
	end

	assign wr_en  = v_s1 & en2 & (kind_c == ST_OK);
	assign clr_en = v_s1 & en2 & (kind_c == ST_CLEAR);

	// entry valid flags: unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (clr_en) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[ch_s1[AW-1:0]] <= 1'b1;
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en2) begin
			tag_s2.vld  <= v_s1;
			tag_s2.kind <= kind_c;
			tag_s2.ch   <= ch_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			err_s2 <= err_s1;
			acc_s2 <= acc_c;
		end
	end

	// ---------------- stage 3: multiply ----------------
	mcpi_mac u_mac (
		.clk        (clk),
		.en         (en3),
		.prop_gain  (prop_gain_q),
		.integ_gain (integ_gain_q),
		.err        (err_s2),
		.acc        (acc_s2),
		.drive_c    (drive_c),
		.sat_c      (sat_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en3) begin
			tag_s3 <= tag_s2;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= tag_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && tag_s3.vld) begin
			out_channel_q <= tag_s3.ch;
			if (tag_s3.kind == ST_OK) begin
				drive_q  <= drive_c;
				status_q <= sat_c ? ST_SAT : ST_OK;
			end else begin
				drive_q  <= '0;
				status_q <= tag_s3.kind;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign out_channel = out_channel_q;
	assign status      = status_q;

endmodule

// ===== dv/multichannel_pi_antiwindup_unit_tb.sv =====
// Self-checking testbench for the multichannel PI controller with integrator clamp.
`timescale 1ns / 1ps
module multichannel_pi_antiwindup_unit_tb;
	import mcpi_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_PRINTS   = 40;
	localparam int PHASES       = 12;
	localparam int PHASE_WORDS  = 150;

	localparam logic signed [ERR_W-1:0] ERR_MAX = 24'sh7FFFFF;
	localparam logic signed [ERR_W-1:0] ERR_MIN = 24'sh800000;
	localparam logic [31:0]             LIM_MAX = 32'h7FFFFFFF;

	typedef struct {
		logic                    op;
		logic [CH_W-1:0]         ch;
		logic signed [ERR_W-1:0] err;
	} pi_word_t;

	typedef struct {
		logic signed [DRV_W-1:0] drive;
		logic [CH_W-1:0]         ch;
		status_t                 stat;
	} pi_result_t;

	// DUT connections; the inputs are known from time zero
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    op = OP_UPDATE;
	logic [CH_W-1:0]         channel = '0;
	logic signed [ERR_W-1:0] error_sample = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [DRV_W-1:0] drive;
	logic [CH_W-1:0]         out_channel;
	logic [1:0]              status;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [3:0]              paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;

	// controller copy: settings and per-channel integrators
	logic [GAIN_W-1:0]       kp_reg = PROP_GAIN_RST;
	logic [GAIN_W-1:0]       ki_reg = INTEG_GAIN_RST;
	logic [LIM_W-1:0]        lim_reg = INTEG_LIM_RST;
	logic [ACT_W-1:0]        active_reg = ACTIVE_RST;
	logic signed [ACC_W-1:0] integ_mem [CHANNELS_DEF];

	pi_word_t   pending_words [$];
	pi_result_t drive_due [$];
	pi_word_t   next_word;
	pi_result_t due;

	int  items_pushed = 0;
	int  items_taken = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  send_gap = 0;
	int  recv_stall = 0;
	int  holds_asked = 0;
	int  holds_served = 0;
	bit  no_idle = 1'b0;

	multichannel_pi_antiwindup_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.channel      (channel),
		.error_sample (error_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive        (drive),
		.out_channel  (out_channel),
		.status       (status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		foreach (integ_mem[i]) integ_mem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// integrate, clamp and form the PI output for one accepted word
	function automatic pi_result_t compute_drive(input pi_word_t w);
		pi_result_t r;
		longint acc, lim, sum, drv;
		r.drive = '0;
		r.ch = w.ch;
		r.stat = ST_OK;
		if (w.op == OP_CLEAR) begin
			foreach (integ_mem[i]) integ_mem[i] = '0;
			r.stat = ST_CLEAR;
		end else if (w.ch >= active_reg || int'(w.ch) >= CHANNELS_DEF) begin
			r.stat = ST_RANGE;
		end else begin
			lim = longint'(lim_reg);
			acc = longint'(integ_mem[w.ch]) + longint'(w.err);
			if (acc > lim) acc = lim;
			if (acc < -lim) acc = -lim;
			integ_mem[w.ch] = acc[ACC_W-1:0];
			sum = longint'(kp_reg) * longint'(w.err) + longint'(ki_reg) * acc;
			drv = (sum + 2048) >>> 12;
			if (drv > 64'sd2147483647) begin
				drv = 64'sd2147483647;
				r.stat = ST_SAT;
			end else if (drv < -64'sd2147483648) begin
				drv = -64'sd2147483648;
				r.stat = ST_SAT;
			end
			r.drive = drv[DRV_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_PRINTS)
			$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void add_word(input logic o, input logic [CH_W-1:0] c,
			input logic signed [ERR_W-1:0] e);
		pi_word_t w;
		w.op = o;
		w.ch = c;
		w.err = e;
		pending_words.push_back(w);
		items_pushed++;
	endfunction

	task automatic wait_drained();
		while (items_taken != items_pushed || drive_due.size() != 0) @(posedge clk);
	endtask

	// register write: setup cycle, then access until pready
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PROP_GAIN:  kp_reg = val[GAIN_W-1:0];
			REG_INTEG_GAIN: ki_reg = val[GAIN_W-1:0];
			REG_INTEG_LIM:  lim_reg = val[LIM_W-1:0];
			REG_ACTIVE:     active_reg = val[ACT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] lim, input logic [31:0] act);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_INTEG_LIM, lim);
		write_reg(REG_ACTIVE, act);
	endtask

	// one random phase; windup phases drive their channels hard in one direction
	task automatic run_phase(input int n_words, input bit windup, input bit neg,
			input bit narrow, input bit pause_mid);
		logic [31:0]             kp, ki, lim, act;
		logic signed [ERR_W-1:0] e;
		logic [CH_W-1:0]         c;
		logic                    o;
		int                      top, mag, tmp;
		case ($urandom_range(0, 3))
			0: kp = 0;
			1: kp = 65535;
			2: kp = PROP_GAIN_RST;
			default: kp = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 3))
			0: ki = 0;
			1: ki = 65535;
			2: ki = INTEG_GAIN_RST;
			default: ki = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 5))
			0: lim = 0;
			1: lim = LIM_MAX;
			2: lim = INTEG_LIM_RST;
			3: lim = $urandom_range(0, 1 << 20);
			default: lim = $urandom() & LIM_MAX;
		endcase
		case ($urandom_range(0, 9))
			0: act = 0;
			1: act = 1;
			2: act = 255;
			3, 4, 5: act = 256;
			default: act = $urandom_range(1, 256);
		endcase
		if (windup) begin
			ki = $urandom_range(32768, 65535);
			lim = $urandom_range(0, 1) ? LIM_MAX : $urandom_range(1 << 28, 32'h7FFFFFFF);
			act = 256;
		end
		set_config(kp, ki, lim, act);
		top = narrow ? 7 : 255;
		if (act != 0 && act - 1 < top) top = act - 1;
		for (int k = 0; k < n_words; k++) begin
			o = (!windup && $urandom_range(0, 49) == 0) ? OP_CLEAR : OP_UPDATE;
			if (act != 0 && $urandom_range(0, 99) < 85)
				c = CH_W'($urandom_range(0, top));
			else
				c = CH_W'($urandom_range(0, 255));
			if (windup) begin
				mag = $urandom_range(1 << 22, (1 << 23) - 1);
				e = neg ? ($urandom_range(0, 9) == 0 ? ERR_MIN : ERR_W'(-mag)) : ERR_W'(mag);
			end else begin
				case ($urandom_range(0, 9))
					0: e = ERR_MAX;
					1: e = ERR_MIN;
					2: begin
						tmp = $urandom_range(0, 64) - 32;
						e = tmp[ERR_W-1:0];
					end
					default: e = ERR_W'($urandom());
				endcase
			end
			add_word(o, c, e);
			// sender stops until the block has returned everything
			if (pause_mid && k == n_words / 2) wait_drained();
		end
		wait_drained();
	endtask

	// stimulus
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);

		// reset settings: extremes, small steps, clear with junk channel
		add_word(OP_UPDATE, 8'd0, ERR_MAX);
		add_word(OP_UPDATE, 8'd0, ERR_MIN);
		add_word(OP_UPDATE, 8'd255, 24'sd0);
		add_word(OP_UPDATE, 8'd1, -24'sd1);
		add_word(OP_UPDATE, 8'd1, 24'sd1);
		add_word(OP_CLEAR, 8'd200, ERR_MIN);
		add_word(OP_UPDATE, 8'd0, 24'sd1);
		wait_drained();

		// full proportional gain, zero integral gain, wide limit, only five channels live
		set_config(65535, 0, LIM_MAX, 5);
		add_word(OP_UPDATE, 8'd4, ERR_MAX);
		add_word(OP_UPDATE, 8'd5, ERR_MIN);
		add_word(OP_UPDATE, 8'd255, 24'sd1);
		add_word(OP_UPDATE, 8'd4, ERR_MAX);
		wait_drained();

		// shrink the limit: channel 4 gets pulled in on its next update
		set_config(0, 65535, 100, 256);
		add_word(OP_UPDATE, 8'd4, 24'sd0);
		add_word(OP_UPDATE, 8'd4, ERR_MIN);
		add_word(OP_UPDATE, 8'd9, 24'sd7);
		wait_drained();

		// no channels live, zero limit
		set_config(PROP_GAIN_RST, INTEG_GAIN_RST, 0, 0);
		add_word(OP_UPDATE, 8'd0, 24'sd5);
		add_word(OP_CLEAR, 8'd0, 24'sd0);
		add_word(OP_UPDATE, 8'd128, -24'sd3);
		wait_drained();

		// random phases
		for (int p = 0; p < PHASES; p++) begin
			no_idle = (p == 1 || p == 9);
			if (p == 4) holds_asked++;
			run_phase(PHASE_WORDS, p % 4 == 2, p == 6 || p == 10, p % 3 == 0, p == 8);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// input driver: holds each word until accepted, then idles a while
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_words.size() != 0) begin
				next_word = pending_words.pop_front();
				in_valid <= 1'b1;
				op <= next_word.op;
				channel <= next_word.ch;
				error_sample <= next_word.err;
				send_gap <= idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			recv_stall <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (recv_stall != 0) begin
			recv_stall <= recv_stall - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) recv_stall <= idle_len();
		end
	end

	// accepted input word: predict its result
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			next_word.op = op;
			next_word.ch = channel;
			next_word.err = error_sample;
			drive_due.push_back(compute_drive(next_word));
			items_taken++;
		end
	end

	// accepted output word: compare with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (drive_due.size() == 0) begin
				report_mismatch("unexpected word, drive", longint'(drive), 0);
			end else begin
				due = drive_due.pop_front();
				if (drive !== due.drive)
					report_mismatch("drive", longint'(drive), longint'(due.drive));
				if (out_channel !== due.ch)
					report_mismatch("out_channel", longint'(out_channel), longint'(due.ch));
				if (status !== due.stat)
					report_mismatch("status", longint'(status), longint'(due.stat));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/mcpi_pkg.sv
rtl/mcpi_mac.sv
rtl/multichannel_pi_antiwindup_unit.sv
dv/multichannel_pi_antiwindup_unit_tb.sv
